// ----- sv/reb_pkg.sv -----
// Shared types, constants and the quadrature transition table for the
// rotary encoder with button block. No dependencies.
package reb_pkg;

    // Default build parameters
    localparam int QUARTERS_PER_DETENT = 4;
    localparam int STEP_WIDTH          = 16;

    // Tick counters and tick thresholds
    localparam int TICK_W = 16;

    // Register indexes on the configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT_ROTATION  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_PRESENT   = 2'd3;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic              INVERT_RESET     = 1'b0;
    localparam logic [TICK_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 16'd600;
    localparam logic              PRESENT_RESET    = 1'b1;

    // Idle A/B levels with pull-ups, A in bit 1
    localparam logic [1:0] AB_IDLE = 2'b11;

    // Input beat layout, lowest bit first
    localparam int S_TDATA_W   = 8;
    localparam int S_BIT_A     = 0;
    localparam int S_BIT_B     = 1;
    localparam int S_BIT_BTN   = 2;
    localparam int S_BIT_TAKE  = 3;

    // Quarter-step delta indexed by {old_ab, new_ab}
    localparam logic signed [1:0] QUAD_DELTA [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    // Button setup handed to the debouncer
    typedef struct packed {
        logic              present;
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_press_ticks;
    } btn_cfg_t;

    // Pending button events
    typedef struct packed {
        logic click;
        logic long_press;
    } btn_flags_t;

    // Saturating tick increment
    function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] v);
        return (v == {TICK_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ----- sv/rotary_encoder_with_button.sv -----
// Top level: configuration registers, encoder and button units, result register.
// Depends on reb_pkg, reb_encoder, reb_button.
//
//  channel   direction  payload (lowest bit first)
//  s_*       in         level_a, level_b, button_level, take_events
//  m_*       out        steps, click, long_press
//  cfg_*     in         register index, write data
//
// One tick per cycle while s_tready is high: each beat updates the state in the
// cycle it is taken and its result lands in the output register on the same edge.
// s_tready stays high while the output register is empty or being drained.
// Synchronous reset (aresetn low) clears all but m_tdata, loads register defaults.
// cfg_ready is always high; writes act from the next tick on.
module rotary_encoder_with_button #(
    parameter int QUARTERS_PER_DETENT = reb_pkg::QUARTERS_PER_DETENT,
    parameter int STEP_WIDTH          = reb_pkg::STEP_WIDTH,
    localparam int M_TDATA_W          = ((STEP_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // level_a, level_b, button_level, take_events, zero fill
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [reb_pkg::S_TDATA_W-1:0]     s_tdata,
    // steps, click, long_press, zero fill
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_TDATA_W-1:0]              m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [reb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [reb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic                          invert_reg;
    reb_pkg::btn_cfg_t             btn_cfg_reg;
    logic                          m_valid_reg;
    logic [M_TDATA_W-1:0]          m_data_reg, m_data_next;
    logic                          in_fire;
    logic                          take;
    logic signed [STEP_WIDTH-1:0]  steps_rep;
    reb_pkg::btn_flags_t           flags_rep;

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign take      = s_tdata[reb_pkg::S_BIT_TAKE];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg                   <= reb_pkg::INVERT_RESET;
            btn_cfg_reg.debounce_ticks   <= reb_pkg::DEBOUNCE_RESET;
            btn_cfg_reg.long_press_ticks <= reb_pkg::LONG_PRESS_RESET;
            btn_cfg_reg.present          <= reb_pkg::PRESENT_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                reb_pkg::REG_INVERT_ROTATION:  invert_reg <= cfg_wdata[0];
                reb_pkg::REG_DEBOUNCE_TICKS:   btn_cfg_reg.debounce_ticks <= cfg_wdata;
                reb_pkg::REG_LONG_PRESS_TICKS: btn_cfg_reg.long_press_ticks <= cfg_wdata;
                reb_pkg::REG_BUTTON_PRESENT:   btn_cfg_reg.present <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    reb_encoder #(
        .QUARTERS   (QUARTERS_PER_DETENT),
        .STEP_WIDTH (STEP_WIDTH)
    ) u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (in_fire),
        .ab        ({s_tdata[reb_pkg::S_BIT_A], s_tdata[reb_pkg::S_BIT_B]}),
        .take      (take),
        .invert    (invert_reg),
        .steps_rep (steps_rep)
    );

    reb_button u_button (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (in_fire),
        .pressed_now (!s_tdata[reb_pkg::S_BIT_BTN]),
        .take        (take),
        .cfg         (btn_cfg_reg),
        .flags_rep   (flags_rep)
    );

    // Result beat packing
    always_comb begin
        m_data_next = '0;
        m_data_next[STEP_WIDTH-1:0] = steps_rep;
        m_data_next[STEP_WIDTH]     = flags_rep.click;
        m_data_next[STEP_WIDTH+1]   = flags_rep.long_press;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- sv/reb_encoder.sv -----
// Quadrature decoder: quarter-step count, saturating pending step count and
// the reported (optionally negated) value. Depends on reb_pkg.
module reb_encoder #(
    parameter int QUARTERS   = reb_pkg::QUARTERS_PER_DETENT,
    parameter int STEP_WIDTH = reb_pkg::STEP_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,        // one tick taken this cycle
    input  logic [1:0]                   ab,         // {A, B}
    input  logic                         take,
    input  logic                         invert,
    output logic signed [STEP_WIDTH-1:0] steps_rep   // value for this tick's result
);

    localparam int QW = $clog2(QUARTERS + 1) + 1;
    localparam logic signed [QW-1:0] Q_POS = QW'(QUARTERS);
    localparam logic signed [QW-1:0] Q_NEG = -Q_POS;
    localparam logic signed [STEP_WIDTH-1:0] STEP_MAX = {1'b0, {(STEP_WIDTH-1){1'b1}}};
    localparam logic signed [STEP_WIDTH-1:0] STEP_MIN = {1'b1, {(STEP_WIDTH-1){1'b0}}};

    logic [1:0]                   last_ab_reg, last_ab_next;
    logic signed [QW-1:0]         quarter_reg, quarter_next;
    logic signed [STEP_WIDTH-1:0] pending_reg, pending_next;
    logic signed [STEP_WIDTH-1:0] pending_upd;
    logic signed [QW-1:0]         quarter_sum;

    // Transition decode and detent step
    always_comb begin
        quarter_sum  = quarter_reg + QW'(reb_pkg::QUAD_DELTA[{last_ab_reg, ab}]);
        last_ab_next = last_ab_reg;
        quarter_next = quarter_reg;
        pending_upd  = pending_reg;
        if (adv && ab != last_ab_reg) begin
            last_ab_next = ab;
            if (quarter_sum >= Q_POS) begin
                quarter_next = '0;
                if (pending_reg != STEP_MAX) pending_upd = pending_reg + 1'b1;
            end else if (quarter_sum <= Q_NEG) begin
                quarter_next = '0;
                if (pending_reg != STEP_MIN) pending_upd = pending_reg - 1'b1;
            end else begin
                quarter_next = quarter_sum;
            end
        end
        pending_next = (adv && take) ? '0 : pending_upd;
    end

    // Reported value, inversion saturates the minimum
    always_comb begin
        if (!invert)
            steps_rep = pending_upd;
        else if (pending_upd == STEP_MIN)
            steps_rep = STEP_MAX;
        else
            steps_rep = -pending_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ab_reg <= reb_pkg::AB_IDLE;
            quarter_reg <= '0;
            pending_reg <= '0;
        end else begin
            last_ab_reg <= last_ab_next;
            quarter_reg <= quarter_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- sv/reb_button.sv -----
// Button debounce with click and long-press detection, one update per tick.
// Depends on reb_pkg.
module reb_button (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  pressed_now,
    input  logic                  take,
    input  reb_pkg::btn_cfg_t     cfg,
    output reb_pkg::btn_flags_t   flags_rep     // flags for this tick's result
);

    logic raw_reg, raw_next;
    logic stable_reg, stable_next;
    logic long_rep_reg, long_rep_next;
    logic click_reg, click_next;
    logic long_reg, long_next;
    logic [reb_pkg::TICK_W-1:0] change_cnt_reg, change_cnt_next;
    logic [reb_pkg::TICK_W-1:0] press_cnt_reg, press_cnt_next;
    logic accept;

    // Debounce, then press/release events
    always_comb begin
        raw_next        = raw_reg;
        stable_next     = stable_reg;
        long_rep_next   = long_rep_reg;
        click_next      = click_reg;
        long_next       = long_reg;
        change_cnt_next = change_cnt_reg;
        press_cnt_next  = press_cnt_reg;
        accept          = 1'b0;
        if (adv && cfg.present) begin
            if (stable_reg) press_cnt_next = reb_pkg::tick_inc(press_cnt_reg);
            raw_next        = pressed_now;
            change_cnt_next = (pressed_now != raw_reg) ? '0
                                                       : reb_pkg::tick_inc(change_cnt_reg);
            accept = (change_cnt_next >= cfg.debounce_ticks) && (pressed_now != stable_reg);
            if (accept) begin
                stable_next = pressed_now;
                if (pressed_now) begin
                    press_cnt_next = '0;
                    long_rep_next  = 1'b0;
                end else if (!long_rep_reg) begin
                    click_next = 1'b1;
                end
            end
            if (stable_next && !long_rep_next && press_cnt_next >= cfg.long_press_ticks) begin
                long_next     = 1'b1;
                long_rep_next = 1'b1;
            end
        end
        flags_rep.click      = click_next;
        flags_rep.long_press = long_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            long_rep_reg   <= 1'b0;
            click_reg      <= 1'b0;
            long_reg       <= 1'b0;
            change_cnt_reg <= '0;
            press_cnt_reg  <= '0;
        end else begin
            raw_reg        <= raw_next;
            stable_reg     <= stable_next;
            long_rep_reg   <= long_rep_next;
            change_cnt_reg <= change_cnt_next;
            press_cnt_reg  <= press_cnt_next;
            // take clears pending events after they are reported
            click_reg      <= (adv && take) ? 1'b0 : click_next;
            long_reg       <= (adv && take) ? 1'b0 : long_next;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for rotary_encoder_with_button: quadrature counting,
// button debounce, click and long press, all register settings.
// Depends on reb_pkg and the RTL top level; a predictor or typed rows check each beat.
`timescale 1ns / 100ps

module tb_top;

    localparam int SW              = reb_pkg::STEP_WIDTH;
    localparam int QPD             = reb_pkg::QUARTERS_PER_DETENT;
    localparam int M_W             = ((SW + 2 + 7) / 8) * 8;
    localparam longint STEP_HI     = (longint'(1) << (SW - 1)) - 1;
    localparam longint STEP_LO     = -STEP_HI - 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RAND_PHASES     = 6;
    localparam int PHASE_TICKS     = 160;

    // One report beat: steps, click, long press
    typedef struct packed {
        logic [SW-1:0] steps;
        logic          click;
        logic          long_press;
    } tick_report_t;

    // Register set written between phases
    typedef struct packed {
        logic        invert;
        logic [15:0] debounce;
        logic [15:0] long_ticks;
        logic        present;
    } reg_set_t;

    // Directed stimulus row; known rows carry a typed report
    typedef struct packed {
        logic [1:0]    set_idx;
        logic          a;
        logic          b;
        logic          btn;
        logic          take;
        logic          known;
        logic [SW-1:0] steps;
        logic          click;
        logic          long_press;
    } dir_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [reb_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [M_W-1:0]                 m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [reb_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [reb_pkg::CFG_DATA_W-1:0] cfg_wdata;

    rotary_encoder_with_button u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Run limit, several times the slowest correct run
    initial begin
        #80_000_000;
        $display("FAILURE");
        $finish;
    end

    // Predicted block state and register copy
    logic                       cfg_invert   = reb_pkg::INVERT_RESET;
    logic [reb_pkg::TICK_W-1:0] cfg_debounce = reb_pkg::DEBOUNCE_RESET;
    logic [reb_pkg::TICK_W-1:0] cfg_long     = reb_pkg::LONG_PRESS_RESET;
    logic                       cfg_present  = reb_pkg::PRESENT_RESET;
    logic [1:0]                 enc_last_ab  = reb_pkg::AB_IDLE;
    int                         enc_quarters = 0;
    longint                     steps_held   = 0;
    bit                         btn_raw, btn_stable, long_done, click_flag, long_flag;
    logic [reb_pkg::TICK_W-1:0] since_change = '0;
    logic [reb_pkg::TICK_W-1:0] since_press  = '0;

    tick_report_t report_queue[$];
    int           fail_count      = 0;
    int           reports_checked = 0;
    int           ticks_sent      = 0;
    int           tx_burst_left   = 0;
    bit           hold_off_req    = 1'b0;
    logic [15:0]  rx_pattern      = 16'hFFFF;

    // Position along the clockwise cycle 11, 01, 00, 10
    function automatic int gray_pos(logic [1:0] ab);
        case (ab)
            2'b11:   return 0;
            2'b01:   return 1;
            2'b00:   return 2;
            default: return 3;
        endcase
    endfunction

    function automatic logic [1:0] ab_at(int pos);
        case (pos & 3)
            0:       return 2'b11;
            1:       return 2'b01;
            2:       return 2'b00;
            default: return 2'b10;
        endcase
    endfunction

    function automatic logic [reb_pkg::TICK_W-1:0] bump(logic [reb_pkg::TICK_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advance the predicted state by one tick and return its report
    function automatic tick_report_t predict_report(bit a, bit b, bit btn, bit take);
        logic [1:0]   ab;
        int           move;
        bit           pressed;
        longint       shown;
        tick_report_t rep;
        ab = {a, b};
        // encoder first
        if (ab != enc_last_ab) begin
            move = (gray_pos(ab) - gray_pos(enc_last_ab)) & 3;
            if (move == 1)
                enc_quarters++;
            else if (move == 3)
                enc_quarters--;
            enc_last_ab = ab;
            if (enc_quarters >= QPD) begin
                if (steps_held < STEP_HI)
                    steps_held++;
                enc_quarters = 0;
            end else if (enc_quarters <= -QPD) begin
                if (steps_held > STEP_LO)
                    steps_held--;
                enc_quarters = 0;
            end
        end
        // then the button, active low
        if (cfg_present) begin
            pressed = !btn;
            if (btn_stable)
                since_press = bump(since_press);
            if (pressed != btn_raw) begin
                btn_raw = pressed;
                since_change = '0;
            end else begin
                since_change = bump(since_change);
            end
            if (since_change >= cfg_debounce && pressed != btn_stable) begin
                btn_stable = pressed;
                if (btn_stable) begin
                    since_press = '0;
                    long_done = 1'b0;
                end else if (!long_done) begin
                    click_flag = 1'b1;
                end
            end
            if (btn_stable && !long_done && since_press >= cfg_long) begin
                long_flag = 1'b1;
                long_done = 1'b1;
            end
        end
        // report, then clear on take
        shown = steps_held;
        if (cfg_invert)
            shown = (shown == STEP_LO) ? STEP_HI : -shown;
        rep.steps      = shown[SW-1:0];
        rep.click      = click_flag;
        rep.long_press = long_flag;
        if (take) begin
            steps_held = 0;
            click_flag = 1'b0;
            long_flag  = 1'b0;
        end
        return rep;
    endfunction

    // Offer one tick beat in bursts; leaves tvalid high after acceptance
    task automatic send_tick(bit a, bit b, bit btn, bit take, bit known,
                             tick_report_t typed);
        logic [reb_pkg::S_TDATA_W-1:0] beat;
        tick_report_t                  pred;
        int                            gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        beat = '0;
        beat[reb_pkg::S_BIT_A]    = a;
        beat[reb_pkg::S_BIT_B]    = b;
        beat[reb_pkg::S_BIT_BTN]  = btn;
        beat[reb_pkg::S_BIT_TAKE] = take;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tx_burst_left--;
        ticks_sent++;
        pred = predict_report(a, b, btn, take);
        report_queue.push_back(known ? typed : pred);
    endtask

    task automatic write_reg(logic [reb_pkg::CFG_ADDR_W-1:0] idx,
                             logic [reb_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            reb_pkg::REG_INVERT_ROTATION:  cfg_invert   = val[0];
            reb_pkg::REG_DEBOUNCE_TICKS:   cfg_debounce = val;
            reb_pkg::REG_LONG_PRESS_TICKS: cfg_long     = val;
            reb_pkg::REG_BUTTON_PRESENT:   cfg_present  = val[0];
            default: ;
        endcase
    endtask

    // Drain, then rewrite all four registers while the block is idle
    task automatic apply_regs(reg_set_t rs);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        tx_burst_left = 0;
        while (report_queue.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(reb_pkg::REG_INVERT_ROTATION, {15'd0, rs.invert});
        write_reg(reb_pkg::REG_DEBOUNCE_TICKS, rs.debounce);
        write_reg(reb_pkg::REG_LONG_PRESS_TICKS, rs.long_ticks);
        write_reg(reb_pkg::REG_BUTTON_PRESENT, {15'd0, rs.present});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver readiness: per-phase pattern plus one long hold-off
    initial begin : rx_drive
        int unsigned slot;
        slot = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= rx_pattern[slot % 16];
                slot++;
            end
        end
    end

    // Compare each report beat with the oldest expectation
    always @(posedge aclk) begin
        tick_report_t want;
        tick_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.steps      = m_tdata[SW-1:0];
            got.click      = m_tdata[SW];
            got.long_press = m_tdata[SW+1];
            if (report_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected report beat: steps %0d click %0d long %0d",
                             $signed(got.steps), got.click, got.long_press);
            end else begin
                want = report_queue.pop_front();
                reports_checked++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("report %0d: expected steps %0d click %0d long %0d",
                                 reports_checked, $signed(want.steps), want.click,
                                 want.long_press);
                        $display("report %0d: got      steps %0d click %0d long %0d",
                                 reports_checked, $signed(got.steps), got.click,
                                 got.long_press);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin : stim
        dir_row_t     rows[$];
        reg_set_t     dir_sets[4];
        reg_set_t     rs;
        tick_report_t typed;
        int           cur_set;
        int           enc_pos;
        int           enc_dir;
        int           btn_left;
        int           deb;
        int           lp;
        int           i;
        int           ph;
        bit           btn_level;
        logic [1:0]   ab;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;

        dir_sets[0] = '{1'b0, reb_pkg::DEBOUNCE_RESET, reb_pkg::LONG_PRESS_RESET, 1'b1};
        dir_sets[1] = '{1'b0, 16'd0, 16'd0, 1'b1};
        dir_sets[2] = '{1'b1, 16'd0, 16'hFFFF, 1'b1};
        dir_sets[3] = '{1'b1, 16'd0, 16'd0, 1'b0};

        // reset defaults: idle, one detent each way, illegal jumps, short bounce
        rows.push_back('{2'd0, 1, 1, 1, 0, 1, '0, 0, 0});
        rows.push_back('{2'd0, 0, 1, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd0, 0, 0, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd0, 1, 0, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd0, 1, 1, 1, 0, 1, SW'(1), 0, 0});
        rows.push_back('{2'd0, 1, 1, 1, 1, 1, SW'(1), 0, 0});
        rows.push_back('{2'd0, 1, 0, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd0, 0, 0, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd0, 0, 1, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd0, 1, 1, 1, 0, 1, '1, 0, 0});
        rows.push_back('{2'd0, 0, 0, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd0, 1, 1, 0, 1, 0, '0, 0, 0});
        rows.push_back('{2'd0, 1, 1, 1, 0, 1, '0, 0, 0});
        // zero thresholds: press gives a long press on the same tick, no click
        rows.push_back('{2'd1, 1, 1, 0, 0, 1, '0, 0, 1});
        rows.push_back('{2'd1, 1, 1, 1, 1, 1, '0, 0, 1});
        rows.push_back('{2'd1, 1, 1, 1, 0, 1, '0, 0, 0});
        // inverted detent, then a short press and release gives a click
        rows.push_back('{2'd2, 0, 1, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd2, 0, 0, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd2, 1, 0, 1, 0, 0, '0, 0, 0});
        rows.push_back('{2'd2, 1, 1, 0, 0, 1, '1, 0, 0});
        rows.push_back('{2'd2, 1, 1, 1, 1, 1, '1, 1, 0});
        rows.push_back('{2'd2, 1, 1, 1, 0, 1, '0, 0, 0});
        // no button wired: presses are ignored
        rows.push_back('{2'd3, 1, 1, 0, 0, 1, '0, 0, 0});
        rows.push_back('{2'd3, 1, 1, 1, 0, 1, '0, 0, 0});
        rows.push_back('{2'd3, 1, 1, 0, 1, 0, '0, 0, 0});

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        cur_set = 0;
        foreach (rows[k]) begin
            if (int'(rows[k].set_idx) != cur_set) begin
                cur_set = int'(rows[k].set_idx);
                apply_regs(dir_sets[cur_set]);
            end
            typed = '{rows[k].steps, rows[k].click, rows[k].long_press};
            send_tick(rows[k].a, rows[k].b, rows[k].btn, rows[k].take, rows[k].known, typed);
        end

        // random phases: mostly clean quadrature with held presses, some noise
        enc_pos = 0;
        enc_dir = 1;
        btn_left = 0;
        btn_level = 1'b1;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            deb = $urandom_range(0, 6);
            lp  = $urandom_range(0, 30);
            rs.invert     = (ph == 5) ? 1'b1 : 1'($urandom_range(0, 1));
            rs.debounce   = 16'(deb);
            rs.long_ticks = 16'(lp);
            rs.present    = (ph != 3);
            apply_regs(rs);
            rx_pattern = (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            if (ph == 2)
                hold_off_req = 1'b1;
            for (i = 0; i < PHASE_TICKS; i++) begin
                if ($urandom_range(0, 99) < 85) begin
                    if ($urandom_range(0, 9) == 0)
                        enc_dir = -enc_dir;
                    if ($urandom_range(0, 3) != 0)
                        enc_pos = (enc_pos + enc_dir) & 3;
                end else begin
                    enc_pos = $urandom_range(0, 3);
                end
                if (btn_left == 0) begin
                    btn_level = ~btn_level;
                    if ($urandom_range(0, 4) == 0)
                        btn_left = $urandom_range(1, 2);
                    else
                        btn_left = $urandom_range(1, deb + lp + 8);
                end
                btn_left--;
                ab = ab_at(enc_pos);
                send_tick(ab[1], ab[0], btn_level, $urandom_range(0, 7) == 0, 1'b0, '0);
            end
        end

        // wind down
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (report_queue.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Sent %0d ticks, checked %0d reports (%0d failures) over directed cases,",
                 ticks_sent, reports_checked, fail_count);
        $display("zero and maximum thresholds, a long receiver hold-off and %0d random setups.",
                 RAND_PHASES);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
